// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ----- sv/rcp_pkg.sv -----
// Types, constants and helper functions of the RESP command parser.
package rcp_pkg;

  localparam int DEF_MAX_ARGS     = 1024;
  localparam int DEF_MAX_BULK_LEN = 536870912;

  localparam int ARGNUM_W = 10;
  localparam logic [ARGNUM_W-1:0] ARGNUM_TOP = '1;

  // Result queue depth; one input beat writes at most two results.
  localparam int OUTQ_DEPTH = 4;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_START,
    PH_INLINE,
    PH_CNT,
    PH_CNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ARG,
    KIND_EMPTY,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          data_byte;
    logic                last_of_arg;
    logic [ARGNUM_W-1:0] arg_number;
  } res_t;

  // Up to two results written into the queue by one beat, first in r0.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic res_t mk_res(input kind_t kind, input logic [7:0] data_byte,
                                  input logic last_of_arg,
                                  input logic [ARGNUM_W-1:0] arg_number);
    res_t r;
    r.kind        = kind;
    r.data_byte   = data_byte;
    r.last_of_arg = last_of_arg;
    r.arg_number  = arg_number;
    return r;
  endfunction

  function automatic logic [ARGNUM_W-1:0] bump_arg(input logic [ARGNUM_W-1:0] n);
    return (n == ARGNUM_TOP) ? n : n + ARGNUM_W'(1);
  endfunction

  // Space, TAB, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

// ----- sv/rcp_parser.sv -----
// Per-byte parse state machine: number decode, bulk counting, inline splitting.
`include "assert_macros.svh"

module rcp_parser #(
  parameter int MAX_ARGS     = rcp_pkg::DEF_MAX_ARGS,
  parameter int MAX_BULK_LEN = rcp_pkg::DEF_MAX_BULK_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [7:0]        stream_byte,
  output rcp_pkg::push_t    push
);

  localparam int NUM_MAX = (MAX_ARGS > MAX_BULK_LEN) ? MAX_ARGS : MAX_BULK_LEN;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int ARGS_W  = $clog2(MAX_ARGS + 1);
  localparam int LEN_W   = $clog2(MAX_BULK_LEN + 1);
  localparam int PROD_W  = NUM_W + 4;
  localparam logic [PROD_W-1:0] LIM_ARGS = PROD_W'(MAX_ARGS);
  localparam logic [PROD_W-1:0] LIM_LEN  = PROD_W'(MAX_BULK_LEN);

  rcp_pkg::phase_t                 phase, phase_next;
  logic [NUM_W-1:0]                accum, accum_next;
  logic                            minus_seen, minus_next;
  logic                            digit_seen, digit_next;
  logic [ARGS_W-1:0]               args_left, args_left_next;
  logic [LEN_W-1:0]                bytes_left, bytes_left_next;
  logic                            held_valid, held_valid_next;
  logic [7:0]                      held_byte, held_byte_next;
  logic [rcp_pkg::ARGNUM_W-1:0]    arg_count, arg_count_next;

  logic                            hv;
  logic [rcp_pkg::ARGNUM_W-1:0]    ac;
  logic [rcp_pkg::ARGNUM_W-1:0]    ac_after;
  logic                            do_inline;
  logic                            err;
  logic                            is_digit;
  logic [PROD_W-1:0]               prod;
  logic [PROD_W-1:0]               limit;
  logic [LEN_W-1:0]                bl_dec;
  logic [ARGS_W-1:0]               al_dec;

  assign is_digit = (stream_byte >= rcp_pkg::CH_ZERO) && (stream_byte <= rcp_pkg::CH_NINE);
  // accum * 10 + digit; digit is the low nibble of an ASCII digit
  assign prod  = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + PROD_W'(stream_byte[3:0]);
  assign limit = (phase == rcp_pkg::PH_CNT) ? LIM_ARGS : LIM_LEN;
  assign bl_dec = bytes_left - LEN_W'(1);
  assign al_dec = (args_left != '0) ? args_left - ARGS_W'(1) : args_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rcp_pkg::PH_START;
      accum      <= '0;
      minus_seen <= 1'b0;
      digit_seen <= 1'b0;
      args_left  <= '0;
      bytes_left <= '0;
      held_valid <= 1'b0;
      arg_count  <= '0;
    end else begin
      phase      <= phase_next;
      accum      <= accum_next;
      minus_seen <= minus_next;
      digit_seen <= digit_next;
      args_left  <= args_left_next;
      bytes_left <= bytes_left_next;
      held_valid <= held_valid_next;
      arg_count  <= arg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
  end

  always_comb begin
    phase_next      = phase;
    accum_next      = accum;
    minus_next      = minus_seen;
    digit_next      = digit_seen;
    args_left_next  = args_left;
    bytes_left_next = bytes_left;
    held_valid_next = held_valid;
    held_byte_next  = held_byte;
    arg_count_next  = arg_count;
    push            = '0;
    hv              = held_valid;
    ac              = arg_count;
    ac_after        = arg_count;
    do_inline       = 1'b0;
    err             = 1'b0;
    if (beat) begin
      case (phase)
        rcp_pkg::PH_START: begin
          hv              = 1'b0;
          ac              = '0;
          arg_count_next  = '0;
          held_valid_next = 1'b0;
          if (stream_byte == rcp_pkg::CH_STAR) begin
            accum_next = '0;
            minus_next = 1'b0;
            digit_next = 1'b0;
            phase_next = rcp_pkg::PH_CNT;
          end else begin
            phase_next = rcp_pkg::PH_INLINE;
            do_inline  = 1'b1;
          end
        end
        rcp_pkg::PH_INLINE: begin
          do_inline = 1'b1;
        end
        rcp_pkg::PH_CNT, rcp_pkg::PH_LEN: begin
          if (is_digit) begin
            if ((minus_seen && prod != '0) || prod > limit) begin
              err = 1'b1;
            end else begin
              accum_next = prod[NUM_W-1:0];
              digit_next = 1'b1;
            end
          end else if (stream_byte == rcp_pkg::CH_MINUS && !minus_seen && !digit_seen) begin
            minus_next = 1'b1;
          end else if (stream_byte == rcp_pkg::CH_CR && digit_seen) begin
            phase_next = (phase == rcp_pkg::PH_CNT) ? rcp_pkg::PH_CNT_LF : rcp_pkg::PH_LEN_LF;
          end else begin
            err = 1'b1;
          end
        end
        rcp_pkg::PH_CNT_LF: begin
          if (stream_byte != rcp_pkg::CH_LF) begin
            err = 1'b1;
          end else begin
            args_left_next = accum[ARGS_W-1:0];
            phase_next = (accum == '0) ? rcp_pkg::PH_START : rcp_pkg::PH_DOLLAR;
          end
        end
        rcp_pkg::PH_DOLLAR: begin
          if (stream_byte != rcp_pkg::CH_DOLLAR) begin
            err = 1'b1;
          end else begin
            accum_next = '0;
            minus_next = 1'b0;
            digit_next = 1'b0;
            phase_next = rcp_pkg::PH_LEN;
          end
        end
        rcp_pkg::PH_LEN_LF: begin
          if (stream_byte != rcp_pkg::CH_LF) begin
            err = 1'b1;
          end else begin
            bytes_left_next = accum[LEN_W-1:0];
            if (accum == '0) begin
              push.v0    = 1'b1;
              push.r0    = rcp_pkg::mk_res(rcp_pkg::KIND_EMPTY, 8'h00, 1'b1, arg_count);
              phase_next = rcp_pkg::PH_TRAIL1;
            end else begin
              phase_next = rcp_pkg::PH_DATA;
            end
          end
        end
        rcp_pkg::PH_DATA: begin
          bytes_left_next = bl_dec;
          push.v0 = 1'b1;
          push.r0 = rcp_pkg::mk_res(rcp_pkg::KIND_ARG, stream_byte, bl_dec == '0, arg_count);
          if (bl_dec == '0) begin
            phase_next = rcp_pkg::PH_TRAIL1;
          end
        end
        rcp_pkg::PH_TRAIL1: begin
          phase_next = rcp_pkg::PH_TRAIL2;
        end
        rcp_pkg::PH_TRAIL2: begin
          args_left_next = al_dec;
          arg_count_next = rcp_pkg::bump_arg(arg_count);
          if (al_dec == '0) begin
            push.v0    = 1'b1;
            push.r0    = rcp_pkg::mk_res(rcp_pkg::KIND_END, 8'h00, 1'b0,
                                         rcp_pkg::bump_arg(arg_count));
            phase_next = rcp_pkg::PH_START;
          end else begin
            phase_next = rcp_pkg::PH_DOLLAR;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase

      if (do_inline) begin
        if (stream_byte == rcp_pkg::CH_LF) begin
          if (hv) begin
            push.v0  = 1'b1;
            push.r0  = rcp_pkg::mk_res(rcp_pkg::KIND_ARG, held_byte, 1'b1, ac);
            ac_after = rcp_pkg::bump_arg(ac);
          end else begin
            ac_after = ac;
          end
          // command end follows the flushed byte, or stands alone
          if (ac_after != '0) begin
            if (hv) begin
              push.v1 = 1'b1;
              push.r1 = rcp_pkg::mk_res(rcp_pkg::KIND_END, 8'h00, 1'b0, ac_after);
            end else begin
              push.v0 = 1'b1;
              push.r0 = rcp_pkg::mk_res(rcp_pkg::KIND_END, 8'h00, 1'b0, ac_after);
            end
          end
          arg_count_next  = '0;
          held_valid_next = 1'b0;
          phase_next      = rcp_pkg::PH_START;
        end else if (rcp_pkg::is_space(stream_byte)) begin
          if (hv) begin
            push.v0         = 1'b1;
            push.r0         = rcp_pkg::mk_res(rcp_pkg::KIND_ARG, held_byte, 1'b1, ac);
            arg_count_next  = rcp_pkg::bump_arg(ac);
            held_valid_next = 1'b0;
          end
        end else begin
          if (hv) begin
            push.v0 = 1'b1;
            push.r0 = rcp_pkg::mk_res(rcp_pkg::KIND_ARG, held_byte, 1'b0, ac);
          end
          held_byte_next  = stream_byte;
          held_valid_next = 1'b1;
        end
      end

      if (err) begin
        phase_next = rcp_pkg::PH_ERROR;
        push.v0    = 1'b1;
        push.v1    = 1'b0;
        push.r0    = rcp_pkg::mk_res(rcp_pkg::KIND_ERROR, 8'h00, 1'b0, '0);
      end
    end
  end

  `ASSERT_PROP(a_error_sticky, clk, rst, (phase == rcp_pkg::PH_ERROR) |=> (phase == rcp_pkg::PH_ERROR), "error state left without reset")
  `ASSERT_PROP(a_push_needs_beat, clk, rst, (push.v0 || push.v1) |-> beat, "result written without an input beat")
  `ASSERT_PROP(a_second_after_first, clk, rst, push.v1 |-> push.v0, "second result without a first")
  `ASSERT_PROP(a_second_is_end, clk, rst, push.v1 |-> (push.r0.kind == rcp_pkg::KIND_ARG && push.r1.kind == rcp_pkg::KIND_END), "second result is not a command end after a byte")

endmodule

// ----- sv/rcp_out_fifo.sv -----
// Result queue: two writes and one read per cycle, feeds the output stream.
`include "assert_macros.svh"

module rcp_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  rcp_pkg::push_t  push,
  output logic            room,
  output logic            head_valid,
  input  logic            head_take,
  output rcp_pkg::res_t   head
);

  localparam int DEPTH = rcp_pkg::OUTQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  rcp_pkg::res_t     mem [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [PTR_W:0]    count, count_next;
  logic [PTR_W:0]    n_push;
  logic              pop;
  logic [PTR_W-1:0]  waddr1;

  assign n_push     = (PTR_W + 1)'(push.v0) + (PTR_W + 1)'(push.v1);
  assign pop        = head_valid && head_take;
  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  // keep space for the largest burst one beat can write
  assign room       = (count <= (PTR_W + 1)'(DEPTH - 2));
  assign waddr1     = wptr + PTR_W'(push.v0);
  assign count_next = count + n_push - (PTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[PTR_W-1:0];
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wptr] <= push.r0;
    end
    if (push.v1) begin
      mem[waddr1] <= push.r1;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, count > (PTR_W + 1)'(DEPTH), "result queue overfilled")
  `ASSERT_PROP(a_push_has_room, clk, rst, (push.v0 || push.v1) |-> room, "results written without room for two")

endmodule

// ----- sv/resp_command_parser.sv -----
// Top level of the RESP command parser: byte stream in, argument results out.
//
//  channel   dir  tdata                           tlast        tuser
//  s_*       in   [7:0] stream_byte               -            -
//  m_*       out  [7:0] data_byte, [17:8] arg_no  last_of_arg  [1:0] kind
//
// One input byte per cycle is taken while the result queue has room; each byte is parsed in the cycle it
// is taken and its zero, one or two results land in a four-entry result queue.
// s_tready is low while more than two results wait in the queue, so a byte
// that ends an inline command (up to two results) always fits.
// rst is synchronous and clears parse state and the queue; no clearing pass.
// A protocol error is sticky: every later byte yields one error result.
module resp_command_parser #(
  parameter int MAX_ARGS     = rcp_pkg::DEF_MAX_ARGS,
  parameter int MAX_BULK_LEN = rcp_pkg::DEF_MAX_BULK_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [17:8] arg_number, [23:18] zero
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // [1:0] kind
);

  rcp_pkg::push_t push;
  rcp_pkg::res_t  head;
  logic           room;
  logic           beat;

  assign s_tready = room;
  assign beat     = s_tvalid && room;

  rcp_parser #(
    .MAX_ARGS     (MAX_ARGS),
    .MAX_BULK_LEN (MAX_BULK_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .stream_byte (s_tdata),
    .push        (push)
  );

  rcp_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (m_tvalid),
    .head_take  (m_tready),
    .head       (head)
  );

  assign m_tdata = {6'b0, head.arg_number, head.data_byte};
  assign m_tlast = head.last_of_arg;
  assign m_tuser = head.kind;

endmodule
